// ===== hdl/tcfd_pkg.sv =====
// Package for the thruster command frame decoder.
// Holds frame layout, character codes, register indexes, reset values and lane types.
// No dependencies.
package tcfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int PULSE_W   = 11;
    localparam int PWR_W     = 7;
    localparam int MAG_W     = 18;  // power (<=99) times span magnitude (<=2047)
    localparam int CFG_ADDR_W = 3;

    localparam int FRAME_LEN     = 13;
    localparam int BUF_BYTES_DEF = 15;

    // byte positions inside a good frame
    localparam int POS_MODE_A = 0;
    localparam int POS_A3     = 1;
    localparam int POS_A4     = 3;
    localparam int POS_A5     = 5;
    localparam int POS_MODE_B = 7;
    localparam int POS_B01    = 8;
    localparam int POS_B2     = 10;
    localparam int POS_LAMP   = 12;

    // character codes
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_1   = 8'h31;
    localparam logic [BYTE_W-1:0] CH_2   = 8'h32;
    localparam logic [BYTE_W-1:0] CH_3   = 8'h33;
    localparam logic [BYTE_W-1:0] CH_4   = 8'h34;
    localparam logic [BYTE_W-1:0] CH_6   = 8'h36;
    localparam logic [BYTE_W-1:0] CH_7   = 8'h37;
    localparam logic [BYTE_W-1:0] CH_8   = 8'h38;
    localparam logic [BYTE_W-1:0] CH_9   = 8'h39;

    // two ASCII digits h,l: value = 10*h + l - 11*'0'
    localparam logic [12:0] PAIR_BIAS = 13'd528;
    localparam logic [PWR_W-1:0] POWER_MAX = 7'd99;

    // power scaling shifts
    localparam logic [1:0] DIV1 = 2'd0;
    localparam logic [1:0] DIV2 = 2'd1;
    localparam logic [1:0] DIV4 = 2'd2;

    // divide by 99: q0 = (m * RECIP_K) >> RECIP_SH is q or q-1 for m < 2^18
    localparam logic [11:0] RECIP_K  = 12'd2647;
    localparam int          RECIP_SH = 18;
    localparam logic [MAG_W-1:0] SPAN_DIV = 18'd99;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FWD_MIN = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FWD_MAX = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REV_MIN = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REV_MAX = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEUTRAL = 3'd4;

    localparam logic [PULSE_W-1:0] FWD_MIN_RST = 11'd1525;
    localparam logic [PULSE_W-1:0] FWD_MAX_RST = 11'd1900;
    localparam logic [PULSE_W-1:0] REV_MIN_RST = 11'd1475;
    localparam logic [PULSE_W-1:0] REV_MAX_RST = 11'd1100;
    localparam logic [PULSE_W-1:0] NEUTRAL_RST = 11'd1500;

    typedef enum logic [1:0] {K_NEUTRAL, K_FWD, K_REV, K_HOLD} t_kind;
    typedef enum logic [1:0] {L_HOLD, L_ON, L_OFF} t_lamp;

    typedef struct packed {
        t_kind            kind;
        logic [PWR_W-1:0] pwr;
    } t_drv;

    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic [PULSE_W-1:0] base;
        logic [MAG_W-1:0]   mag;
    } t_prod;

    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic [PULSE_W-1:0] base;
        logic [MAG_W-1:0]   mag;
        logic [PULSE_W-1:0] q0;
    } t_quot;

endpackage

// ===== hdl/thruster_command_frame_decoder.sv =====
// Thruster command frame decoder: serial bytes in, six pulse widths and lamp state out.
// Depends on tcfd_pkg (constants, character codes, lane types).
//
// Usage: one byte (or a gap timeout) is taken per transfer, one per clock at most.
// A frame closes on a newline, on a timeout, or when BUF_BYTES bytes are held; a
// closing transfer with at least one buffered byte yields exactly one result. The
// closing transfer loads the frame snapshot; a decode stage, a span multiply stage,
// a reciprocal divide-by-99 estimate stage and the output register, which corrects
// the quotient, follow in that order. Results queue in those stages, so input keeps
// flowing while a result waits; the input stalls only once all stages are full.
// Configuration writes take effect at once and must be made while idle.
module thruster_command_frame_decoder #(
    parameter int BUF_BYTES = tcfd_pkg::BUF_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [tcfd_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [tcfd_pkg::PULSE_W-1:0]         i_cfg_wdata,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [tcfd_pkg::BYTE_W-1:0]          i_rx_byte,
    input  logic                                 i_gap_timeout,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [tcfd_pkg::PULSE_W-1:0]         o_pulse_t0,
    output logic [tcfd_pkg::PULSE_W-1:0]         o_pulse_t1,
    output logic [tcfd_pkg::PULSE_W-1:0]         o_pulse_t2,
    output logic [tcfd_pkg::PULSE_W-1:0]         o_pulse_t3,
    output logic [tcfd_pkg::PULSE_W-1:0]         o_pulse_t4,
    output logic [tcfd_pkg::PULSE_W-1:0]         o_pulse_t5,
    output logic                                 o_lamp_on,
    output logic                                 o_frame_error
);

    localparam int CNT_W = $clog2(BUF_BYTES + 1);
    localparam int NTHR  = 6;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tcfd_pkg::PULSE_W-1:0] r_fwd_min, r_fwd_max, r_rev_min, r_rev_max, r_neutral;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_min <= tcfd_pkg::FWD_MIN_RST;
            r_fwd_max <= tcfd_pkg::FWD_MAX_RST;
            r_rev_min <= tcfd_pkg::REV_MIN_RST;
            r_rev_max <= tcfd_pkg::REV_MAX_RST;
            r_neutral <= tcfd_pkg::NEUTRAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tcfd_pkg::CFG_FWD_MIN: r_fwd_min <= i_cfg_wdata;
                tcfd_pkg::CFG_FWD_MAX: r_fwd_max <= i_cfg_wdata;
                tcfd_pkg::CFG_REV_MIN: r_rev_min <= i_cfg_wdata;
                tcfd_pkg::CFG_REV_MAX: r_rev_max <= i_cfg_wdata;
                tcfd_pkg::CFG_NEUTRAL: r_neutral <= i_cfg_wdata;
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_out_valid;
    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d, w_rdy_e;
    logic w_accept;

    assign w_rdy_e  = !r_out_valid || i_out_ready;
    assign w_rdy_d  = !r_d_valid || w_rdy_e;
    assign w_rdy_c  = !r_c_valid || w_rdy_d;
    assign w_rdy_b  = !r_b_valid || w_rdy_c;
    assign w_rdy_a  = !r_a_valid || w_rdy_b;
    assign w_accept = i_in_valid && w_rdy_a;
    assign o_in_ready = w_rdy_a;

    // ------------------------------------------------------------------
    // Frame assembly. Only the first FRAME_LEN bytes are kept; the length up
    // to the first NUL and a trailing CR are tracked as bytes arrive.
    // ------------------------------------------------------------------
    logic [tcfd_pkg::FRAME_LEN-1:0][tcfd_pkg::BYTE_W-1:0] r_buf, n_buf;
    logic [CNT_W-1:0] r_cnt, n_cnt, r_len, n_len, w_eff_len;
    logic             r_nul, n_nul, r_cr, n_cr;
    logic             w_end, w_event, w_good;

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        n_len = r_len;
        n_nul = r_nul;
        n_cr  = r_cr;
        w_end = 1'b0;
        if (w_accept) begin
            if (i_gap_timeout || i_rx_byte == tcfd_pkg::CH_LF) begin
                w_end = 1'b1;
            end else begin
                for (int i = 0; i < tcfd_pkg::FRAME_LEN; i++) begin
                    if (r_cnt == CNT_W'(i)) n_buf[i] = i_rx_byte;
                end
                n_cnt = r_cnt + 1'b1;
                if (!r_nul && i_rx_byte != tcfd_pkg::CH_NUL) n_len = r_len + 1'b1;
                if (i_rx_byte == tcfd_pkg::CH_NUL) n_nul = 1'b1;
                n_cr = (i_rx_byte == tcfd_pkg::CH_CR);
                if (n_cnt == CNT_W'(BUF_BYTES)) w_end = 1'b1;
            end
        end
        // a trailing CR only shortens the length when no NUL came before it
        w_eff_len = (n_cr && !n_nul) ? n_len - 1'b1 : n_len;
        w_event   = w_end && (n_cnt != '0);
        w_good    = (w_eff_len == CNT_W'(tcfd_pkg::FRAME_LEN));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_len <= '0;
            r_nul <= 1'b0;
            r_cr  <= 1'b0;
        end else if (w_end) begin
            r_cnt <= '0;
            r_len <= '0;
            r_nul <= 1'b0;
            r_cr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_len <= n_len;
            r_nul <= n_nul;
            r_cr  <= n_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    // ------------------------------------------------------------------
    // Stage A: snapshot of a closed frame
    // ------------------------------------------------------------------
    logic [tcfd_pkg::FRAME_LEN-1:0][tcfd_pkg::BYTE_W-1:0] r_a_frm;
    logic r_a_good;

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_frm  <= n_buf;
            r_a_good <= w_good;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: decode modes, scale and clamp powers
    // ------------------------------------------------------------------
    function automatic logic [tcfd_pkg::PWR_W-1:0] f_power(
        input logic [tcfd_pkg::BYTE_W-1:0] hi,
        input logic [tcfd_pkg::BYTE_W-1:0] lo,
        input logic [1:0]                  sh
    );
        logic [12:0] raw;
        logic [11:0] v;
        logic [11:0] s;
        raw = 13'(hi) * 13'd10 + 13'(lo);
        // negative values clamp to zero whatever the rounding
        v = (raw < tcfd_pkg::PAIR_BIAS) ? 12'd0 : 12'(raw - tcfd_pkg::PAIR_BIAS);
        s = v >> sh;
        return (s > 12'(tcfd_pkg::POWER_MAX)) ? tcfd_pkg::POWER_MAX : s[tcfd_pkg::PWR_W-1:0];
    endfunction

    function automatic tcfd_pkg::t_drv f_drv(
        input tcfd_pkg::t_kind             kind,
        input logic [tcfd_pkg::PWR_W-1:0]  pwr
    );
        tcfd_pkg::t_drv d;
        d.kind = kind;
        d.pwr  = pwr;
        return d;
    endfunction

    tcfd_pkg::t_drv   w_b_drv [NTHR];
    tcfd_pkg::t_lamp  w_b_lamp;
    tcfd_pkg::t_drv   r_b_drv [NTHR];
    tcfd_pkg::t_lamp  r_b_lamp;
    logic             r_b_err;

    always_comb begin
        logic [tcfd_pkg::PWR_W-1:0] a3, a3h, a4, a4q, a5, a5h, a5q, b01, b2;
        tcfd_pkg::t_drv nz;
        a3  = f_power(r_a_frm[tcfd_pkg::POS_A3],  r_a_frm[tcfd_pkg::POS_A3+1],  tcfd_pkg::DIV1);
        a3h = f_power(r_a_frm[tcfd_pkg::POS_A3],  r_a_frm[tcfd_pkg::POS_A3+1],  tcfd_pkg::DIV2);
        a4  = f_power(r_a_frm[tcfd_pkg::POS_A4],  r_a_frm[tcfd_pkg::POS_A4+1],  tcfd_pkg::DIV1);
        a4q = f_power(r_a_frm[tcfd_pkg::POS_A4],  r_a_frm[tcfd_pkg::POS_A4+1],  tcfd_pkg::DIV4);
        a5  = f_power(r_a_frm[tcfd_pkg::POS_A5],  r_a_frm[tcfd_pkg::POS_A5+1],  tcfd_pkg::DIV1);
        a5h = f_power(r_a_frm[tcfd_pkg::POS_A5],  r_a_frm[tcfd_pkg::POS_A5+1],  tcfd_pkg::DIV2);
        a5q = f_power(r_a_frm[tcfd_pkg::POS_A5],  r_a_frm[tcfd_pkg::POS_A5+1],  tcfd_pkg::DIV4);
        b01 = f_power(r_a_frm[tcfd_pkg::POS_B01], r_a_frm[tcfd_pkg::POS_B01+1], tcfd_pkg::DIV1);
        b2  = f_power(r_a_frm[tcfd_pkg::POS_B2],  r_a_frm[tcfd_pkg::POS_B2+1],  tcfd_pkg::DIV1);
        nz  = f_drv(tcfd_pkg::K_NEUTRAL, '0);

        // rear group: thrusters 5, 4, 3
        unique case (r_a_frm[tcfd_pkg::POS_MODE_A])
            tcfd_pkg::CH_1: begin
                w_b_drv[5] = f_drv(tcfd_pkg::K_FWD, a5);
                w_b_drv[4] = f_drv(tcfd_pkg::K_FWD, a4q);
                w_b_drv[3] = f_drv(tcfd_pkg::K_FWD, a3h);
            end
            tcfd_pkg::CH_2: begin
                w_b_drv[5] = f_drv(tcfd_pkg::K_FWD, a5);
                w_b_drv[4] = f_drv(tcfd_pkg::K_FWD, a4);
                w_b_drv[3] = f_drv(tcfd_pkg::K_FWD, a3);
            end
            tcfd_pkg::CH_3: begin
                w_b_drv[5] = f_drv(tcfd_pkg::K_FWD, a5h);
                w_b_drv[4] = f_drv(tcfd_pkg::K_FWD, a4q);
                w_b_drv[3] = f_drv(tcfd_pkg::K_FWD, a3);
            end
            tcfd_pkg::CH_4: begin
                w_b_drv[5] = f_drv(tcfd_pkg::K_REV, a5);
                w_b_drv[4] = nz;
                w_b_drv[3] = f_drv(tcfd_pkg::K_FWD, a3);
            end
            tcfd_pkg::CH_6: begin
                w_b_drv[5] = f_drv(tcfd_pkg::K_FWD, a5);
                w_b_drv[4] = nz;
                w_b_drv[3] = f_drv(tcfd_pkg::K_REV, a3);
            end
            tcfd_pkg::CH_7: begin
                // all three from power A5
                w_b_drv[5] = f_drv(tcfd_pkg::K_REV, a5);
                w_b_drv[4] = f_drv(tcfd_pkg::K_REV, a5q);
                w_b_drv[3] = f_drv(tcfd_pkg::K_REV, a5h);
            end
            tcfd_pkg::CH_8: begin
                w_b_drv[5] = f_drv(tcfd_pkg::K_REV, a5);
                w_b_drv[4] = f_drv(tcfd_pkg::K_REV, a4);
                w_b_drv[3] = f_drv(tcfd_pkg::K_REV, a3);
            end
            tcfd_pkg::CH_9: begin
                w_b_drv[5] = f_drv(tcfd_pkg::K_REV, a5h);
                w_b_drv[4] = f_drv(tcfd_pkg::K_REV, a4q);
                w_b_drv[3] = f_drv(tcfd_pkg::K_REV, a3);
            end
            default: begin
                w_b_drv[5] = nz;
                w_b_drv[4] = nz;
                w_b_drv[3] = nz;
            end
        endcase

        // vertical group: thrusters 0, 1, 2
        unique case (r_a_frm[tcfd_pkg::POS_MODE_B])
            tcfd_pkg::CH_2: begin
                w_b_drv[0] = f_drv(tcfd_pkg::K_FWD, b01);
                w_b_drv[1] = f_drv(tcfd_pkg::K_FWD, b01);
                w_b_drv[2] = f_drv(tcfd_pkg::K_FWD, b2);
            end
            tcfd_pkg::CH_8: begin
                w_b_drv[0] = f_drv(tcfd_pkg::K_REV, b01);
                w_b_drv[1] = f_drv(tcfd_pkg::K_REV, b01);
                w_b_drv[2] = f_drv(tcfd_pkg::K_REV, b2);
            end
            tcfd_pkg::CH_4: begin
                w_b_drv[0] = f_drv(tcfd_pkg::K_FWD, b01);
                w_b_drv[1] = f_drv(tcfd_pkg::K_FWD, b01);
                w_b_drv[2] = f_drv(tcfd_pkg::K_HOLD, '0);
            end
            tcfd_pkg::CH_6: begin
                w_b_drv[0] = f_drv(tcfd_pkg::K_REV, b01);
                w_b_drv[1] = f_drv(tcfd_pkg::K_REV, b01);
                w_b_drv[2] = f_drv(tcfd_pkg::K_HOLD, '0);
            end
            default: begin
                w_b_drv[0] = nz;
                w_b_drv[1] = nz;
                w_b_drv[2] = nz;
            end
        endcase

        unique case (r_a_frm[tcfd_pkg::POS_LAMP])
            tcfd_pkg::CH_1: w_b_lamp = tcfd_pkg::L_ON;
            tcfd_pkg::CH_2: w_b_lamp = tcfd_pkg::L_OFF;
            default:        w_b_lamp = tcfd_pkg::L_HOLD;
        endcase

        // a bad frame touches nothing
        if (!r_a_good) begin
            for (int i = 0; i < NTHR; i++) w_b_drv[i] = f_drv(tcfd_pkg::K_HOLD, '0);
            w_b_lamp = tcfd_pkg::L_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b) begin
            r_b_drv  <= w_b_drv;
            r_b_lamp <= w_b_lamp;
            r_b_err  <= !r_a_good;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: power times span magnitude
    // ------------------------------------------------------------------
    tcfd_pkg::t_prod  w_c_lane [NTHR];
    tcfd_pkg::t_prod  r_c_lane [NTHR];
    tcfd_pkg::t_lamp  r_c_lamp;
    logic             r_c_err;

    always_comb begin
        logic [tcfd_pkg::PULSE_W-1:0] lo_v, hi_v, magd;
        logic [tcfd_pkg::PULSE_W:0]   diff;
        for (int i = 0; i < NTHR; i++) begin
            if (r_b_drv[i].kind == tcfd_pkg::K_REV) begin
                lo_v = r_rev_min;
                hi_v = r_rev_max;
            end else begin
                lo_v = r_fwd_min;
                hi_v = r_fwd_max;
            end
            diff = {1'b0, hi_v} - {1'b0, lo_v};
            magd = diff[tcfd_pkg::PULSE_W] ? tcfd_pkg::PULSE_W'(12'd0 - diff)
                                           : diff[tcfd_pkg::PULSE_W-1:0];
            w_c_lane[i].kind = r_b_drv[i].kind;
            w_c_lane[i].neg  = diff[tcfd_pkg::PULSE_W];
            w_c_lane[i].base = lo_v;
            w_c_lane[i].mag  = {11'd0, r_b_drv[i].pwr} * {7'd0, magd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_c) begin
            r_c_lane <= w_c_lane;
            r_c_lamp <= r_b_lamp;
            r_c_err  <= r_b_err;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: reciprocal multiply, quotient estimate low by at most one
    // ------------------------------------------------------------------
    tcfd_pkg::t_quot  w_d_lane [NTHR];
    tcfd_pkg::t_quot  r_d_lane [NTHR];
    tcfd_pkg::t_lamp  r_d_lamp;
    logic             r_d_err;

    always_comb begin
        logic [29:0] prod;
        for (int i = 0; i < NTHR; i++) begin
            prod = {12'd0, r_c_lane[i].mag} * {18'd0, tcfd_pkg::RECIP_K};
            w_d_lane[i].kind = r_c_lane[i].kind;
            w_d_lane[i].neg  = r_c_lane[i].neg;
            w_d_lane[i].base = r_c_lane[i].base;
            w_d_lane[i].mag  = r_c_lane[i].mag;
            w_d_lane[i].q0   = tcfd_pkg::PULSE_W'(prod >> tcfd_pkg::RECIP_SH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_d) begin
            r_d_lane <= w_d_lane;
            r_d_lamp <= r_c_lamp;
            r_d_err  <= r_c_err;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: quotient correction, sign, offset; pulse state is the output
    // ------------------------------------------------------------------
    logic [NTHR-1:0][tcfd_pkg::PULSE_W-1:0] r_pulse, w_e_pulse;
    logic r_lamp, w_e_lamp, r_err;

    always_comb begin
        logic [tcfd_pkg::MAG_W-1:0]   rem;
        logic [tcfd_pkg::PULSE_W-1:0] q;
        for (int i = 0; i < NTHR; i++) begin
            rem = r_d_lane[i].mag - tcfd_pkg::MAG_W'(r_d_lane[i].q0) * tcfd_pkg::SPAN_DIV;
            q   = r_d_lane[i].q0 + tcfd_pkg::PULSE_W'(rem >= tcfd_pkg::SPAN_DIV);
            case (r_d_lane[i].kind)
                tcfd_pkg::K_FWD,
                tcfd_pkg::K_REV:     w_e_pulse[i] = r_d_lane[i].neg ? r_d_lane[i].base - q
                                                                     : r_d_lane[i].base + q;
                tcfd_pkg::K_NEUTRAL: w_e_pulse[i] = r_neutral;
                default:             w_e_pulse[i] = r_pulse[i];
            endcase
        end
        case (r_d_lamp)
            tcfd_pkg::L_ON:  w_e_lamp = 1'b1;
            tcfd_pkg::L_OFF: w_e_lamp = 1'b0;
            default:         w_e_lamp = r_lamp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NTHR; i++) r_pulse[i] <= tcfd_pkg::NEUTRAL_RST;
            r_lamp <= 1'b0;
            r_err  <= 1'b0;
        end else if (w_rdy_e && r_d_valid) begin
            r_pulse <= w_e_pulse;
            r_lamp  <= w_e_lamp;
            r_err   <= r_d_err;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy_a) r_a_valid   <= w_accept && w_event;
            if (w_rdy_b) r_b_valid   <= r_a_valid;
            if (w_rdy_c) r_c_valid   <= r_b_valid;
            if (w_rdy_d) r_d_valid   <= r_c_valid;
            if (w_rdy_e) r_out_valid <= r_d_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pulse_t0    = r_pulse[0];
    assign o_pulse_t1    = r_pulse[1];
    assign o_pulse_t2    = r_pulse[2];
    assign o_pulse_t3    = r_pulse[3];
    assign o_pulse_t4    = r_pulse[4];
    assign o_pulse_t5    = r_pulse[5];
    assign o_lamp_on     = r_lamp;
    assign o_frame_error = r_err;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(BUF_BYTES))
        else $error("byte count reached buffer size without closing the frame");

    a_len_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= r_cnt)
        else $error("frame length exceeds buffered byte count");

    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_valid && w_rdy_e && r_d_err) |=>
            (r_pulse == $past(r_pulse) && o_frame_error && o_out_valid))
        else $error("bad frame changed pulse outputs");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_a_valid && r_b_valid && r_c_valid && r_d_valid && r_out_valid))
        else $error("input stalled while a pipeline stage is free");

endmodule
